### rtl/rlee_pkg.sv
// ---------------------------------------------------------------------------
// Leader-election engine package
// Message and result codes, role codes, register indexes and reset values.
// ---------------------------------------------------------------------------
package rlee_pkg;

   localparam int NODES_MAX_DEFAULT = 8;
   localparam int TERM_BITS_DEFAULT = 32;

   // longest run of results for one item
   localparam int RUN_MAX = 7;

   localparam int REQ_DATA_BITS = 80;
   localparam int RSP_DATA_BITS = 56;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   // incoming event kinds
   localparam logic [2:0] IN_TICK       = 3'd0;
   localparam logic [2:0] IN_HB_REQ     = 3'd1;
   localparam logic [2:0] IN_VOTE_REQ   = 3'd2;
   localparam logic [2:0] IN_VOTE_REPLY = 3'd3;
   localparam logic [2:0] IN_HB_REPLY   = 3'd4;

   // outgoing result kinds
   localparam logic [2:0] OUT_HB_REPLY   = 3'd0;
   localparam logic [2:0] OUT_VOTE_REPLY = 3'd1;
   localparam logic [2:0] OUT_HB_REQ     = 3'd2;
   localparam logic [2:0] OUT_VOTE_REQ   = 3'd3;
   localparam logic [2:0] OUT_ERROR      = 3'd4;

   localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
   localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
   localparam logic [1:0] ROLE_LEADER    = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NODE_ID     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NODE_COUNT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HB_INTERVAL = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT_MIN = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT_MAX = 3'd4;

   localparam logic [2:0]  RST_NODE_ID     = 3'd0;
   localparam logic [3:0]  RST_NODE_COUNT  = 4'd3;
   localparam logic [15:0] RST_HB_INTERVAL = 16'd50;
   localparam logic [15:0] RST_TIMEOUT_MIN = 16'd150;
   localparam logic [15:0] RST_TIMEOUT_MAX = 16'd300;

endpackage

### rtl/raft_leader_election_engine_top.sv
// ---------------------------------------------------------------------------
// Leader-election engine top level
// Role, term and vote bookkeeping of one cluster node, with reply and
// broadcast generation.
// ---------------------------------------------------------------------------
// Usage:
//  - req_* carries one event per transfer: a tick or a message (kind in
//    req_tuser). State is updated at the edge the transfer completes.
//  - rsp_* carries results one per transfer; rsp_tlast marks the final
//    result caused by one event. Replies and errors are single results;
//    an election start or a heartbeat round is a run to every peer
//    (at most seven results).
//  - csr_* writes one configuration register per transfer; write only
//    while no results are outstanding.
//  - An event's results pass from the run generator to the result register.
//  - Throughput: one event per cycle while each causes at most one result
//    and rsp_tready does not stall; an event causing a run of results holds
//    req_tready low until its last result enters the single result register.
//  - Reset (synchronous, active high) returns to follower, term zero, and
//    the default configuration. A stalled rsp_tready holds the result
//    register; one further event is taken while a single result waits.
// ---------------------------------------------------------------------------
module raft_leader_election_engine_top #(
   parameter int NODES_MAX = rlee_pkg::NODES_MAX_DEFAULT,
   parameter int TERM_BITS = rlee_pkg::TERM_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // sender[2:0], target[5:3], msg_term[37:6], candidate[40:38],
   // granted_in[41], timeout_draw[57:42], msg_ident[73:58], zero[79:74]
   input  logic [rlee_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // kind[2:0]
   input  logic [2:0]                            req_tuser,
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // dest[2:0], out_term[34:3], granted[35], reply_id[51:36],
   // role[53:52], zero[55:54]
   output logic [rlee_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // out_kind[2:0]
   output logic [2:0]                            rsp_tuser,
   output logic                                  rsp_tlast,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rlee_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rlee_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import rlee_pkg::*;

   localparam int PTR_BITS = ($clog2(NODES_MAX) + 1 > 4) ? $clog2(NODES_MAX) + 1 : 4;
   localparam int CNT_BITS = ($clog2(NODES_MAX + 1) > 4) ? $clog2(NODES_MAX + 1) : 4;
   localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(NODES_MAX);
   localparam logic [CNT_BITS-1:0] CNT_RUN = CNT_BITS'(RUN_MAX);

   // configuration
   logic [2:0]  node_id_ff;
   logic [3:0]  node_count_ff;
   logic [15:0] hb_interval_ff;
   logic [15:0] timeout_min_ff;
   logic [15:0] timeout_max_ff;

   // node state
   logic [1:0]           role_ff, role_in;
   logic [TERM_BITS-1:0] term_ff, term_in;
   logic                 voted_ff, voted_in;
   logic [2:0]           vcand_ff, vcand_in;
   logic [3:0]           vcnt_ff, vcnt_in;
   logic [15:0]          elapsed_ff, elapsed_in;
   logic [15:0]          hb_ff, hb_in;

   // pending run
   logic                job_valid_ff;
   logic [2:0]          job_left_ff;
   logic [PTR_BITS-1:0] job_ptr_ff;
   logic [2:0]          job_kind_ff;
   logic                job_granted_ff;
   logic [15:0]         job_rid_ff;
   logic [31:0]         job_term_ff;
   logic [1:0]          job_role_ff;

   // result register
   logic        rsp_valid_ff;
   logic [2:0]  rsp_kind_ff;
   logic [2:0]  rsp_dest_ff;
   logic [31:0] rsp_term_ff;
   logic        rsp_granted_ff;
   logic [15:0] rsp_rid_ff;
   logic [1:0]  rsp_role_ff;
   logic        rsp_last_ff;

   // request fields
   logic [2:0]  in_kind, in_sender, in_target, in_cand;
   logic [31:0] in_term_raw;
   logic        in_granted;
   logic [15:0] in_draw, in_mid;
   logic [TERM_BITS-1:0] mterm;

   assign in_kind     = req_tuser;
   assign in_sender   = req_tdata[2:0];
   assign in_target   = req_tdata[5:3];
   assign in_term_raw = req_tdata[37:6];
   assign in_cand     = req_tdata[40:38];
   assign in_granted  = req_tdata[41];
   assign in_draw     = req_tdata[57:42];
   assign in_mid      = req_tdata[73:58];

   generate
      if (TERM_BITS >= 32) begin : g_term_wide
         assign mterm = TERM_BITS'(in_term_raw);
      end else begin : g_term_narrow
         // saturate terms beyond the counter's range
         assign mterm = (|in_term_raw[31:TERM_BITS]) ? {TERM_BITS{1'b1}}
                                                      : in_term_raw[TERM_BITS-1:0];
      end
   endgenerate

   // handshakes
   logic out_load, job_emit, req_accept, load_job;

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign job_emit   = job_valid_ff && out_load;
   assign req_tready = !job_valid_ff || (job_emit && (job_left_ff == 3'd1));
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // derived values for the step
   logic [15:0] iv_m1, timeout_hi, timeout_lo_cl, timeout_t, elapsed_inc;
   logic [TERM_BITS-1:0] term_inc;
   logic [2:0]  nc_half;
   logic [3:0]  vcnt_inc;
   logic        mterm_gt, mterm_eq, misaddr;

   assign iv_m1         = (hb_interval_ff == 16'd0) ? 16'd0 : hb_interval_ff - 16'd1;
   assign timeout_hi    = (timeout_max_ff < timeout_min_ff) ? timeout_min_ff : timeout_max_ff;
   assign timeout_lo_cl = (in_draw < timeout_min_ff) ? timeout_min_ff : in_draw;
   assign timeout_t     = (timeout_lo_cl > timeout_hi) ? timeout_hi : timeout_lo_cl;
   assign elapsed_inc   = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign term_inc      = (&term_ff) ? term_ff : term_ff + TERM_BITS'(1);
   assign nc_half       = node_count_ff[3:1];
   assign vcnt_inc      = (vcnt_ff == 4'hF) ? vcnt_ff : vcnt_ff + 4'd1;
   assign mterm_gt      = mterm > term_ff;
   assign mterm_eq      = mterm == term_ff;
   assign misaddr       = (in_kind >= IN_HB_REQ) && (in_kind <= IN_HB_REPLY)
                          && (in_target != node_id_ff);

   // peers of a broadcast run
   logic [CNT_BITS-1:0] cnt_ext, cluster, n_peers;
   logic                self_in;
   logic [2:0]          bcast_n;

   assign cnt_ext = CNT_BITS'(node_count_ff);
   assign cluster = (cnt_ext > CNT_MAX) ? CNT_MAX : cnt_ext;
   assign self_in = CNT_BITS'(node_id_ff) < cluster;
   assign n_peers = cluster - CNT_BITS'(self_in);
   assign bcast_n = (n_peers > CNT_RUN) ? 3'(RUN_MAX) : n_peers[2:0];

   // step decision
   logic        run_en, run_bcast, run_granted;
   logic [2:0]  run_kind;
   logic [15:0] run_rid;
   logic [2:0]  run_n;

   always_comb begin
      role_in     = role_ff;
      term_in     = term_ff;
      voted_in    = voted_ff;
      vcand_in    = vcand_ff;
      vcnt_in     = vcnt_ff;
      elapsed_in  = elapsed_ff;
      hb_in       = hb_ff;
      run_en      = 1'b0;
      run_bcast   = 1'b0;
      run_kind    = OUT_ERROR;
      run_granted = 1'b0;
      run_rid     = 16'd0;
      if (misaddr) begin
         run_en  = 1'b1;
         run_rid = in_mid;
      end else begin
         case (in_kind)
            IN_TICK: begin
               if (role_ff == ROLE_LEADER) begin
                  if (hb_ff == 16'd0) begin
                     run_en    = 1'b1;
                     run_bcast = 1'b1;
                     run_kind  = OUT_HB_REQ;
                     hb_in     = iv_m1;
                  end else begin
                     hb_in = hb_ff - 16'd1;
                  end
               end else if (elapsed_inc >= timeout_t) begin
                  // start an election with a self vote
                  role_in    = ROLE_CANDIDATE;
                  term_in    = term_inc;
                  voted_in   = 1'b1;
                  vcand_in   = node_id_ff;
                  vcnt_in    = 4'd1;
                  elapsed_in = 16'd0;
                  run_en     = 1'b1;
                  run_bcast  = 1'b1;
                  if (nc_half == 3'd0) begin
                     role_in  = ROLE_LEADER;
                     run_kind = OUT_HB_REQ;
                     hb_in    = iv_m1;
                  end else begin
                     run_kind = OUT_VOTE_REQ;
                  end
               end else begin
                  elapsed_in = elapsed_inc;
               end
            end
            IN_HB_REQ: begin
               if (mterm_gt) begin
                  term_in    = mterm;
                  role_in    = ROLE_FOLLOWER;
                  voted_in   = 1'b0;
                  elapsed_in = 16'd0;
               end else if (mterm_eq) begin
                  role_in    = ROLE_FOLLOWER;
                  elapsed_in = 16'd0;
               end
               run_en   = 1'b1;
               run_kind = OUT_HB_REPLY;
               run_rid  = in_mid;
            end
            IN_VOTE_REQ: begin
               if (mterm_gt) begin
                  term_in  = mterm;
                  role_in  = ROLE_FOLLOWER;
                  voted_in = 1'b0;
               end
               if ((mterm_gt || mterm_eq)
                   && (mterm_gt || !voted_ff || (vcand_ff == in_cand))) begin
                  voted_in    = 1'b1;
                  vcand_in    = in_cand;
                  run_granted = 1'b1;
                  elapsed_in  = 16'd0;
               end
               run_en   = 1'b1;
               run_kind = OUT_VOTE_REPLY;
               run_rid  = in_mid;
            end
            IN_VOTE_REPLY: begin
               if (mterm_gt) begin
                  term_in    = mterm;
                  role_in    = ROLE_FOLLOWER;
                  voted_in   = 1'b0;
                  elapsed_in = 16'd0;
               end else if (mterm_eq && in_granted && (role_ff == ROLE_CANDIDATE)) begin
                  vcnt_in = vcnt_inc;
                  if (vcnt_inc > {1'b0, nc_half}) begin
                     role_in   = ROLE_LEADER;
                     run_en    = 1'b1;
                     run_bcast = 1'b1;
                     run_kind  = OUT_HB_REQ;
                     hb_in     = iv_m1;
                  end
               end
            end
            IN_HB_REPLY: begin
               if (mterm_gt) begin
                  term_in    = mterm;
                  role_in    = ROLE_FOLLOWER;
                  voted_in   = 1'b0;
                  elapsed_in = 16'd0;
               end
            end
            default: begin
               // unknown kinds are dropped
            end
         endcase
      end
   end

   assign run_n    = run_bcast ? bcast_n : 3'd1;
   assign load_job = req_accept && run_en && (run_n != 3'd0);

   // next peer after the current one, skipping this node
   logic [PTR_BITS-1:0] ptr_p1, ptr_adv, ptr_first;

   assign ptr_p1    = job_ptr_ff + PTR_BITS'(1);
   assign ptr_adv   = (ptr_p1 == PTR_BITS'(node_id_ff)) ? job_ptr_ff + PTR_BITS'(2) : ptr_p1;
   assign ptr_first = run_bcast ? ((node_id_ff == 3'd0) ? PTR_BITS'(1) : PTR_BITS'(0))
                                : PTR_BITS'(in_sender);

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff     <= RST_NODE_ID;
         node_count_ff  <= RST_NODE_COUNT;
         hb_interval_ff <= RST_HB_INTERVAL;
         timeout_min_ff <= RST_TIMEOUT_MIN;
         timeout_max_ff <= RST_TIMEOUT_MAX;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NODE_ID:     node_id_ff     <= csr_data[2:0];
            CSR_NODE_COUNT:  node_count_ff  <= csr_data[3:0];
            CSR_HB_INTERVAL: hb_interval_ff <= csr_data;
            CSR_TIMEOUT_MIN: timeout_min_ff <= csr_data;
            CSR_TIMEOUT_MAX: timeout_max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff    <= ROLE_FOLLOWER;
         term_ff    <= '0;
         voted_ff   <= 1'b0;
         vcand_ff   <= 3'd0;
         vcnt_ff    <= 4'd0;
         elapsed_ff <= 16'd0;
         hb_ff      <= 16'd0;
      end else if (req_accept) begin
         role_ff    <= role_in;
         term_ff    <= term_in;
         voted_ff   <= voted_in;
         vcand_ff   <= vcand_in;
         vcnt_ff    <= vcnt_in;
         elapsed_ff <= elapsed_in;
         hb_ff      <= hb_in;
      end
   end

   // run generator; a new run replaces the one whose last result leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         job_left_ff  <= 3'd0;
      end else if (load_job) begin
         job_valid_ff <= 1'b1;
         job_left_ff  <= run_n;
      end else if (job_emit) begin
         job_left_ff <= job_left_ff - 3'd1;
         if (job_left_ff == 3'd1) begin
            job_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_job) begin
         job_ptr_ff     <= ptr_first;
         job_kind_ff    <= run_kind;
         job_granted_ff <= run_granted;
         job_rid_ff     <= run_rid;
         job_term_ff    <= 32'(term_in);
         job_role_ff    <= role_in;
      end else if (job_emit) begin
         job_ptr_ff <= ptr_adv;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (job_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_emit) begin
         rsp_kind_ff    <= job_kind_ff;
         rsp_dest_ff    <= job_ptr_ff[2:0];
         rsp_term_ff    <= job_term_ff;
         rsp_granted_ff <= job_granted_ff;
         rsp_rid_ff     <= job_rid_ff;
         rsp_role_ff    <= job_role_ff;
         rsp_last_ff    <= (job_left_ff == 3'd1);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_role_ff, rsp_rid_ff, rsp_granted_ff,
                        rsp_term_ff, rsp_dest_ff};

   // checks
   a_run_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> job_valid_ff)
      else $error("non-final result without a pending run");

   a_job_left: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> job_left_ff != 3'd0)
      else $error("pending run with no results left");

   a_term_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> term_ff >= $past(term_ff))
      else $error("term decreased");

   a_candidate_voted: assert property (@(posedge clock) disable iff (reset)
      role_ff == ROLE_CANDIDATE |-> voted_ff)
      else $error("candidate without a self vote");

endmodule
